// ===== rtl/core/ptsg_pkg.sv =====
// Package of the probe train schedule generator: payload structs, codes,
// controller command and status types and fixed-point helper functions.
// It depends on nothing else.
package ptsg_pkg;

  localparam int unsigned TimeW = 48;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic        kind;
    logic [23:0] load_count;
    logic [13:0] load_size;
    logic [16:0] load_rate;
  } in_t;

  typedef struct packed {
    logic             slot_valid;
    logic             packet_class;
    logic [23:0]      slot_index;
    logic [TimeW-1:0] offset_ns;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    CFG_MIN_RATE     = 3'd0,
    CFG_MAX_RATE     = 3'd1,
    CFG_MIN_GAP      = 3'd2,
    CFG_MAX_GAP      = 3'd3,
    CFG_TAIL_GAP     = 3'd4,
    CFG_HEAD_COUNT   = 3'd5,
    CFG_TAIL_COUNT   = 3'd6,
    CFG_INSPECT_SIZE = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_LOAD = 2'd1,
    PH_HEAD = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_LATCH, OP_START, OP_DISPATCH, OP_DIVGO, OP_TAKE, OP_JUDGE, OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    DS_LOAD, DS_HEAD0, DS_STEP, DS_RATE, DS_MIN
  } div_sel_e;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DISPATCH, S_DIVGO, S_DIVWAIT, S_JUDGE, S_FINISH
  } state_e;

  typedef struct packed {
    op_e      op;
    div_sel_e sel;
  } cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   cnt_zero;
    logic   fill;
    logic   div_done;
    logic   min_branch;
    logic   out_free;
  } sts_t;

  // Multiplication by 8000 as 8192 - 128 - 64.
  function automatic logic [63:0] mul8000(input logic [63:0] x);
    mul8000 = (x << 13) - (x << 7) - (x << 6);
  endfunction

  function automatic logic [TimeW-1:0] sat_time(input logic [63:0] v);
    sat_time = (v > 64'(TimeMax)) ? TimeMax : v[TimeW-1:0];
  endfunction

endpackage

// ===== rtl/core/probe_train_schedule_generator.sv =====
// One input transaction yields one slot of the probe train. Tail slots and
// advances after the end need no division, load slots and the first head
// slot one, and other head slots two or three (none once filling): each
// division runs through one shared radix-2 divider. A held result delays
// the next one. Uses ptsg_pkg, ptsg_ctrl, ptsg_dp.
module probe_train_schedule_generator
  import ptsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [29:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  cmd_t cmd;
  sts_t sts;

  ptsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptsg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== rtl/core/ptsg_div.sv =====
// Radix-2 restoring divider of the probe train schedule generator.
// Divides a 64-bit value by a nonzero 48-bit value; uses ptsg_pkg.
module ptsg_div
  import ptsg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      num_i,
  input  logic [TimeW-1:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [TimeW-1:0] rem_q, rem_d, den_q;
  logic [63:0]      quo_q, quo_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [TimeW:0]   shifted, trial;
  logic             ge;

  assign shifted = {rem_q, quo_q[63]};
  assign ge      = shifted >= {1'b0, den_q};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[TimeW-1:0] : shifted[TimeW-1:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/ptsg_dp.sv =====
// Datapath of the probe train schedule generator: configuration and train
// state, operand selection, the shared divider and the output register.
// Uses ptsg_pkg and ptsg_div.
module ptsg_dp
  import ptsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [29:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  logic [16:0] min_rate_q, max_rate_q;
  logic [29:0] min_gap_q, max_gap_q, tail_gap_q;
  logic [11:0] head_count_q, tail_count_q;
  logic [13:0] inspect_size_q;

  in_t              item_q;
  phase_e           phase_q;
  logic [23:0]      cnt_q;
  logic [TimeW-1:0] last_q, t_q;
  logic [31:0]      sweep_q, r_q;
  logic [39:0]      bt_q;
  logic [11:0]      pl_q;
  logic             fill_q;
  logic [23:0]      hcount_q;
  logic [13:0]      hsize_q;
  logic [16:0]      hrate_q;
  logic [37:0]      prod_q;
  logic             out_valid_q;
  out_t             out_q;

  logic             div_start, div_done;
  logic [63:0]      div_num, div_quo;
  logic [TimeW-1:0] div_den;
  logic [31:0]      min_q8, mag;
  logic             neg;
  logic [TimeW:0]   add_max, add_min, add_tail;
  logic [TimeW-1:0] sat_max, sat_min, sat_tail, diff;
  logic             ok, over;
  logic [24:0]      cnt_inc;
  logic [11:0]      pl_dec;
  out_t             fin_out;

  assign min_q8 = {7'd0, min_rate_q, 8'd0};
  assign neg    = min_q8 < sweep_q;
  assign mag    = neg ? (sweep_q - min_q8) : (min_q8 - sweep_q);

  assign add_max  = {1'b0, last_q} + (TimeW+1)'(max_gap_q);
  assign add_min  = {1'b0, last_q} + (TimeW+1)'(min_gap_q);
  assign add_tail = {1'b0, last_q} + (TimeW+1)'(tail_gap_q);
  assign sat_max  = add_max[TimeW] ? TimeMax : add_max[TimeW-1:0];
  assign sat_min  = add_min[TimeW] ? TimeMax : add_min[TimeW-1:0];
  assign sat_tail = add_tail[TimeW] ? TimeMax : add_tail[TimeW-1:0];

  assign diff = t_q - last_q;
  assign ok   = (t_q >= last_q) && (diff <= TimeW'(max_gap_q)) && (diff >= TimeW'(min_gap_q));
  assign over = !ok && (t_q > last_q) && (diff > TimeW'(max_gap_q));

  assign cnt_inc = {1'b0, cnt_q} + 25'd1;
  assign pl_dec  = pl_q - 12'd1;

  always_comb begin
    div_num = '0;
    div_den = TimeW'(1);
    unique case (cmd_i.sel)
      DS_LOAD: begin
        div_num = mul8000(64'(prod_q));
        div_den = (hrate_q == '0) ? TimeW'(1) : TimeW'(hrate_q);
      end
      DS_HEAD0: begin
        div_num = mul8000(64'(bt_q));
        div_den = (max_rate_q == '0) ? TimeW'(1) : TimeW'(max_rate_q);
      end
      DS_STEP: begin
        div_num = 64'(mag);
        div_den = TimeW'(pl_q);
      end
      DS_RATE: begin
        div_num = mul8000(64'(bt_q)) << 8;
        div_den = (r_q == '0) ? TimeW'(1) : TimeW'(r_q);
      end
      DS_MIN: begin
        div_num = mul8000(64'(bt_q)) << 8;
        div_den = (t_q == '0) ? TimeW'(1) : t_q;
      end
      default: begin
        div_num = '0;
        div_den = TimeW'(1);
      end
    endcase
  end

  always_comb begin
    fin_out = '0;
    if (phase_q != PH_DONE) begin
      fin_out.slot_valid   = 1'b1;
      fin_out.packet_class = phase_q != PH_LOAD;
      fin_out.slot_index   = cnt_q;
      fin_out.offset_ns    = t_q;
      unique case (phase_q)
        PH_LOAD: fin_out.last = (cnt_inc >= {1'b0, hcount_q}) && (head_count_q == '0);
        PH_HEAD: fin_out.last = (pl_dec == '0) && (tail_count_q == '0);
        default: fin_out.last = pl_dec == '0;
      endcase
    end
  end

  assign div_start = cmd_i.op == OP_DIVGO;

  ptsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q     <= 17'd50;
      max_rate_q     <= 17'd1000;
      min_gap_q      <= 30'd40000;
      max_gap_q      <= 30'd400000;
      tail_gap_q     <= 30'd300000;
      head_count_q   <= 12'd80;
      tail_count_q   <= 12'd20;
      inspect_size_q <= 14'd1472;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RATE:     min_rate_q     <= cfg_wdata_i[16:0];
        CFG_MAX_RATE:     max_rate_q     <= cfg_wdata_i[16:0];
        CFG_MIN_GAP:      min_gap_q      <= cfg_wdata_i;
        CFG_MAX_GAP:      max_gap_q      <= cfg_wdata_i;
        CFG_TAIL_GAP:     tail_gap_q     <= cfg_wdata_i;
        CFG_HEAD_COUNT:   head_count_q   <= cfg_wdata_i[11:0];
        CFG_TAIL_COUNT:   tail_count_q   <= cfg_wdata_i[11:0];
        CFG_INSPECT_SIZE: inspect_size_q <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      cnt_q       <= '0;
      last_q      <= '0;
      sweep_q     <= '0;
      bt_q        <= '0;
      pl_q        <= '0;
      fill_q      <= 1'b0;
      hcount_q    <= '0;
      hsize_q     <= '0;
      hrate_q     <= 17'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_START: begin
          if (!item_q.kind) begin
            hcount_q <= item_q.load_count;
            hsize_q  <= item_q.load_size;
            hrate_q  <= item_q.load_rate;
            bt_q     <= 40'(item_q.load_count) * 40'(item_q.load_size);
            last_q   <= '0;
            sweep_q  <= '0;
            fill_q   <= 1'b0;
            cnt_q    <= '0;
            if (item_q.load_count != '0) begin
              phase_q <= PH_LOAD;
              pl_q    <= '0;
            end else if (head_count_q != '0) begin
              phase_q <= PH_HEAD;
              pl_q    <= head_count_q;
            end else begin
              phase_q <= PH_DONE;
              pl_q    <= '0;
            end
          end
        end
        OP_TAKE: begin
          unique case (cmd_i.sel)
            DS_HEAD0: begin
              sweep_q <= {7'd0, max_rate_q, 8'd0};
              fill_q  <= 1'b0;
            end
            DS_MIN:   sweep_q <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
            default: ;
          endcase
        end
        OP_JUDGE: begin
          if (ok) begin
            sweep_q <= r_q;
          end else if (over) begin
            fill_q <= 1'b1;
          end
        end
        OP_FINISH: begin
          unique case (phase_q)
            PH_LOAD: begin
              if (cnt_inc >= {1'b0, hcount_q}) begin
                cnt_q <= '0;
                if (head_count_q != '0) begin
                  phase_q <= PH_HEAD;
                  pl_q    <= head_count_q;
                end else begin
                  phase_q <= PH_DONE;
                  pl_q    <= '0;
                end
              end else begin
                cnt_q <= cnt_inc[23:0];
              end
            end
            PH_HEAD: begin
              bt_q   <= bt_q + 40'(inspect_size_q);
              last_q <= t_q;
              cnt_q  <= cnt_inc[23:0];
              if (pl_dec == '0) begin
                if (tail_count_q != '0) begin
                  phase_q <= PH_TAIL;
                  pl_q    <= tail_count_q;
                end else begin
                  phase_q <= PH_DONE;
                  pl_q    <= pl_dec;
                end
              end else begin
                pl_q <= pl_dec;
              end
            end
            PH_TAIL: begin
              last_q <= t_q;
              pl_q   <= pl_dec;
              cnt_q  <= cnt_inc[23:0];
              if (pl_dec == '0) begin
                phase_q <= PH_DONE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        if (in_valid_i) begin
          item_q <= in_data_i;
        end
      end
      OP_DISPATCH: begin
        prod_q <= 38'(hsize_q) * 38'(cnt_q);
        t_q    <= (phase_q == PH_TAIL) ? sat_tail : sat_max;
      end
      OP_TAKE: begin
        unique case (cmd_i.sel)
          DS_STEP:  r_q <= neg ? (sweep_q - div_quo[31:0]) : (sweep_q + div_quo[31:0]);
          DS_MIN:   ;
          default:  t_q <= sat_time(div_quo);
        endcase
      end
      OP_JUDGE: begin
        if (!ok) begin
          t_q <= over ? sat_max : sat_min;
        end
      end
      OP_FINISH: begin
        out_q <= fin_out;
      end
      default: ;
    endcase
  end

  assign sts_o.phase      = phase_q;
  assign sts_o.cnt_zero   = cnt_q == '0;
  assign sts_o.fill       = fill_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.min_branch = !ok && !over;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/ptsg_ctrl.sv =====
// Controller of the probe train schedule generator: sequences the datapath
// through latch, start, dispatch, division, judge and finish steps. Uses ptsg_pkg.
module ptsg_ctrl
  import ptsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_START;
      S_START: state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts_i.phase)
          PH_LOAD: begin
            state_d = S_DIVGO;
            sel_d   = DS_LOAD;
          end
          PH_HEAD: begin
            if (sts_i.cnt_zero) begin
              state_d = S_DIVGO;
              sel_d   = DS_HEAD0;
            end else if (sts_i.fill) begin
              state_d = S_FINISH;
            end else begin
              state_d = S_DIVGO;
              sel_d   = DS_STEP;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_DIVGO: state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (sts_i.div_done) begin
          unique case (sel_q)
            DS_STEP: begin
              state_d = S_DIVGO;
              sel_d   = DS_RATE;
            end
            DS_RATE: state_d = S_JUDGE;
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_JUDGE: begin
        if (sts_i.min_branch) begin
          state_d = S_DIVGO;
          sel_d   = DS_MIN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE:     cmd_o.op = OP_LATCH;
      S_START:    cmd_o.op = OP_START;
      S_DISPATCH: cmd_o.op = OP_DISPATCH;
      S_DIVGO:    cmd_o.op = OP_DIVGO;
      S_DIVWAIT:  cmd_o.op = sts_i.div_done ? OP_TAKE : OP_NONE;
      S_JUDGE:    cmd_o.op = OP_JUDGE;
      S_FINISH:   cmd_o.op = sts_i.out_free ? OP_FINISH : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DS_LOAD;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  a_divgo_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVGO |=> state_q == S_DIVWAIT)
    else $error("Division launch not followed by wait.");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIVWAIT)
    else $error("Division finished outside the wait state.");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_FINISH |-> sts_i.out_free)
    else $error("Result written over a pending transaction.");

endmodule
